// File: rtl/core/weighted_random_selector_macros.svh
// ----------------------------------------------------------------------------
// Weighted random selector assertion macros
// Concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_SELECTOR_MACROS_SVH
`define WEIGHTED_RANDOM_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("weighted_random_selector assertion failed");
// next-cycle implication
`define WRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("weighted_random_selector assertion failed");
`else
`define WRS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WRS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// Types, codes and constants shared by the weighted random selector.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int WGT_W     = 4;
    localparam int IDX_IN_W  = 4;
    localparam int CAT_W     = 8;
    localparam int RND_W     = 32;
    localparam int BIT_CNT_W = $clog2(RND_W);
    localparam int CNT_CFG_W = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [WGT_W-1:0] WGT_DEFAULT = 4'd1;

    // input commands
    localparam logic [1:0] CMD_SET_CAT = 2'd0;
    localparam logic [1:0] CMD_SET_WGT = 2'd1;
    localparam logic [1:0] CMD_SELECT  = 2'd2;

    // register index (word address bit)
    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic [CAT_W-1:0] CAT_A_UP = 8'h41;
    localparam logic [CAT_W-1:0] CAT_A_LO = 8'h61;
    localparam logic [CAT_W-1:0] CAT_B_UP = 8'h42;
    localparam logic [CAT_W-1:0] CAT_B_LO = 8'h62;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MOD,
        ST_SCAN,
        ST_ADJ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic ready;
        logic sum_en;
        logic mod_en;
        logic scan_en;
        logic adj_en;
        logic out_en;
    } ctl_t;

    typedef struct packed {
        logic select_go;
        logic sum_done;
        logic empty;
        logic mod_done;
        logic hit;
        logic out_free;
    } sts_t;

    function automatic logic [WGT_W-1:0] cat_weight(input logic [CAT_W-1:0] code);
        logic [WGT_W-1:0] w;
        w = 4'd1;
        if (code == CAT_A_UP || code == CAT_A_LO) begin
            w = 4'd3;
        end else if (code == CAT_B_UP || code == CAT_B_LO) begin
            w = 4'd2;
        end
        return w;
    endfunction

endpackage

// File: rtl/core/weighted_random_selector.sv
// ----------------------------------------------------------------------------
// weighted_random_selector
// Roulette-wheel pick over a table of per-entry weights.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): commands 0 and 1 write one weight of the
//   table and produce no result; command 2 selects; command 3 is dropped.
//   Result channel (m_valid/m_ready): one transaction per select, carrying
//   the chosen entry and a status bit (1 when the list is empty or the total
//   weight is zero).
//   Config: APB-style write of entry_count at byte address 0, pready tied high.
// Flow:
//   A select sums the weights of the n clamped entries through the
//   registered table read, runs the one-bit-per-cycle remainder unit over
//   the random word, scans for the draw, then adjusts and outputs.
//   s_ready is high only while the sequencer is idle.
// Reset: the table reads as weight 1 for every entry until written (per-entry
//   valid bits, no clearing pass); entry_count and the last pick clear.
// Stall: a finished result is held in the output register; the block keeps
//   taking write commands and starts the next select, which waits for the
//   output register before it completes.
// ----------------------------------------------------------------------------
`include "weighted_random_selector_macros.svh"

module weighted_random_selector #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wrs_pkg::PADDR_W-1:0]   paddr,
    input  logic [wrs_pkg::PDATA_W-1:0]   pwdata,
    output logic [wrs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [wrs_pkg::IDX_IN_W-1:0]  s_entry_index,
    input  logic [wrs_pkg::CAT_W-1:0]     s_category_code,
    input  logic [wrs_pkg::WGT_W-1:0]     s_weight_value,
    input  logic [wrs_pkg::RND_W-1:0]     s_random_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wrs_pkg::IDX_IN_W-1:0]  m_chosen_index,
    output logic                          m_status
);
    import wrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = $clog2(MAX_ENTRIES * 15 + 1);

    ctl_t ctl;
    sts_t sts;

    // configuration
    logic [CNT_CFG_W-1:0] entry_count_reg;
    logic                 cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_we) begin
            entry_count_reg <= pwdata[CNT_CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ENTRY_COUNT) begin
            prdata = PDATA_W'(entry_count_reg);
        end
    end

    // table write path
    logic                 in_acc;
    logic                 tbl_we;
    logic [IDX_W-1:0]     tbl_waddr;
    logic [WGT_W-1:0]     tbl_wdata;
    logic [IDX_W-1:0]     tbl_raddr;
    logic [WGT_W-1:0]     tbl_rdata;
    logic [MAX_ENTRIES-1:0] vld_reg;
    logic                 vld_q_reg;
    logic [WGT_W-1:0]     wgt;

    assign s_ready   = ctl.ready;
    assign in_acc    = s_valid && s_ready;
    assign tbl_waddr = IDX_W'(s_entry_index);
    assign tbl_wdata = (s_command == CMD_SET_CAT) ? cat_weight(s_category_code)
                                                  : s_weight_value;
    assign tbl_we    = in_acc && (s_command == CMD_SET_CAT || s_command == CMD_SET_WGT)
                       && (int'(s_entry_index) < MAX_ENTRIES);

    wrs_ram #(
        .WIDTH (WGT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (tbl_we) begin
            vld_reg[tbl_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        vld_q_reg <= vld_reg[tbl_raddr];
    end

    // never-written entries read as the reset weight
    assign wgt = vld_q_reg ? tbl_rdata : WGT_DEFAULT;

    // datapath registers
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     dat_idx_reg, dat_idx_next;
    logic                 pend_reg, pend_next;
    logic [SUM_W-1:0]     total_reg, total_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [SUM_W:0]       rem_reg, rem_next;
    logic [RND_W-1:0]     rnd_reg, rnd_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [IDX_W-1:0]     res_pick_reg, res_pick_next;
    logic                 res_empty_reg, res_empty_next;
    logic                 m_valid_reg, m_valid_next;
    logic [IDX_IN_W-1:0]  m_chosen_reg, m_chosen_next;
    logic                 m_status_reg, m_status_next;
    logic [IDX_IN_W-1:0]  last_shown_reg, last_shown_next;
    logic                 last_valid_reg, last_valid_next;

    // shared unit operands and results
    logic [SUM_W-1:0]     add_a;
    logic [SUM_W-1:0]     add_sum;
    logic [SUM_W:0]       rem_sh;
    logic [SUM_W:0]       total_ext;
    logic [SUM_W-1:0]     draw;
    logic                 issue;
    logic                 adv;
    logic [CNT_W-1:0]     pick_inc;
    logic [CNT_W-1:0]     n_clamp;

    assign add_a     = ctl.sum_en ? total_reg : acc_reg;
    assign add_sum   = add_a + SUM_W'(wgt);
    assign total_ext = {1'b0, total_reg};
    assign rem_sh    = {rem_reg[SUM_W-1:0], rnd_reg[RND_W-1]};
    assign draw      = rem_reg[SUM_W-1:0] + SUM_W'(1);
    assign pick_inc  = CNT_W'(pick_reg) + CNT_W'(1);
    assign n_clamp   = (int'(entry_count_reg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                            : CNT_W'(entry_count_reg);
    assign tbl_raddr = IDX_W'(idx_reg);

    assign sts.select_go = in_acc && (s_command == CMD_SELECT);
    assign sts.sum_done  = (idx_reg == n_reg) && !pend_reg;
    assign sts.empty     = (n_reg == '0) || (total_reg == '0);
    assign sts.mod_done  = (bit_cnt_reg == '0);
    assign sts.hit       = ctl.scan_en && pend_reg && (draw <= add_sum);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign adv = last_valid_reg && (int'(pick_reg) == int'(last_shown_reg))
                 && (n_reg > CNT_W'(1));

    always_comb begin
        n_next          = n_reg;
        idx_next        = idx_reg;
        dat_idx_next    = dat_idx_reg;
        pend_next       = pend_reg;
        total_next      = total_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        rnd_next        = rnd_reg;
        bit_cnt_next    = bit_cnt_reg;
        pick_next       = pick_reg;
        res_pick_next   = res_pick_reg;
        res_empty_next  = res_empty_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_chosen_next   = m_chosen_reg;
        m_status_next   = m_status_reg;
        last_shown_next = last_shown_reg;
        last_valid_next = last_valid_reg;
        issue           = 1'b0;

        if (sts.select_go) begin
            n_next         = n_clamp;
            idx_next       = '0;
            pend_next      = 1'b0;
            total_next     = '0;
            rnd_next       = s_random_word;
            res_empty_next = 1'b0;
        end

        if (ctl.sum_en) begin
            issue = (idx_reg != n_reg);
            if (pend_reg) begin
                total_next = add_sum;
            end
            if (sts.sum_done) begin
                rem_next     = '0;
                bit_cnt_next = '1;
                if (sts.empty) begin
                    res_empty_next = 1'b1;
                    res_pick_next  = '0;
                end
            end
        end

        if (ctl.mod_en) begin
            // one quotient bit per cycle
            rem_next     = (rem_sh >= total_ext) ? (rem_sh - total_ext) : rem_sh;
            rnd_next     = rnd_reg << 1;
            bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
            if (sts.mod_done) begin
                idx_next  = '0;
                pend_next = 1'b0;
                acc_next  = '0;
            end
        end

        if (ctl.scan_en) begin
            issue = (idx_reg != n_reg) && !sts.hit;
            if (pend_reg) begin
                acc_next = add_sum;
            end
            if (sts.hit) begin
                pick_next = dat_idx_reg;
            end
        end

        if (ctl.sum_en || ctl.scan_en) begin
            pend_next = issue;
            if (issue) begin
                idx_next     = idx_reg + CNT_W'(1);
                dat_idx_next = IDX_W'(idx_reg);
            end
        end

        if (ctl.adj_en) begin
            res_pick_next = pick_reg;
            if (adv) begin
                res_pick_next = (pick_inc == n_reg) ? '0 : IDX_W'(pick_inc);
            end
        end

        if (ctl.out_en && sts.out_free) begin
            m_valid_next  = 1'b1;
            m_chosen_next = IDX_IN_W'(res_pick_reg);
            m_status_next = res_empty_reg;
            if (!res_empty_reg) begin
                last_shown_next = IDX_IN_W'(res_pick_reg);
                last_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            last_shown_reg <= '0;
            last_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            last_shown_reg <= last_shown_next;
            last_valid_reg <= last_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        dat_idx_reg   <= dat_idx_next;
        pend_reg      <= pend_next;
        total_reg     <= total_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        rnd_reg       <= rnd_next;
        bit_cnt_reg   <= bit_cnt_next;
        pick_reg      <= pick_next;
        res_pick_reg  <= res_pick_next;
        res_empty_reg <= res_empty_next;
        m_chosen_reg  <= m_chosen_next;
        m_status_reg  <= m_status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_chosen_index = m_chosen_reg;
    assign m_status       = m_status_reg;

    wrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .ctl     (ctl)
    );

    logic rem_in_range;
    logic draw_in_range;
    logic pick_in_range;
    logic pick_moved;

    assign rem_in_range  = rem_reg < total_ext;
    assign draw_in_range = (draw != '0) && (draw <= total_reg);
    assign pick_in_range = int'(res_pick_reg) < int'(n_reg);
    assign pick_moved    = int'(res_pick_reg) != int'(last_shown_reg);

    `WRS_ASSERT_IMP(a_rem_below_total, aclk, aresetn, ctl.mod_en, rem_in_range)
    `WRS_ASSERT_IMP(a_draw_in_range, aclk, aresetn, ctl.scan_en, draw_in_range)
    `WRS_ASSERT_IMP(a_pick_in_range, aclk, aresetn, ctl.out_en && !res_empty_reg, pick_in_range)
    `WRS_ASSERT_NXT(a_no_repeat, aclk, aresetn, ctl.adj_en && adv, pick_moved)
    `WRS_ASSERT_NXT(a_result_loaded, aclk, aresetn, ctl.out_en && sts.out_free, m_valid_reg)

endmodule

// File: rtl/core/wrs_ram.sv
// ----------------------------------------------------------------------------
// wrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wrs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/wrs_ctrl.sv
// ----------------------------------------------------------------------------
// wrs_ctrl
// Sequencer for a select: sum pass, bit-serial modulo, scan pass, adjust, output.
// ----------------------------------------------------------------------------
module wrs_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  wrs_pkg::sts_t sts,
    output wrs_pkg::ctl_t ctl
);
    import wrs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (sts.select_go) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sts.sum_done) begin
                    state_next = sts.empty ? ST_OUT : ST_MOD;
                end
            end
            ST_MOD: begin
                if (sts.mod_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.hit) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE: ctl.ready   = 1'b1;
            ST_SUM:  ctl.sum_en  = 1'b1;
            ST_MOD:  ctl.mod_en  = 1'b1;
            ST_SCAN: ctl.scan_en = 1'b1;
            ST_ADJ:  ctl.adj_en  = 1'b1;
            ST_OUT:  ctl.out_en  = 1'b1;
            default: ctl = '0;
        endcase
    end

endmodule
